/* rtl/rff_pkg.sv */
`default_nettype none

package rff_pkg;

    localparam int FIFO_DEPTH = 4;

    localparam logic [2:0] STATUS_ACCEPTED  = 3'd0;
    localparam logic [2:0] STATUS_WRONG_ID  = 3'd1;
    localparam logic [2:0] STATUS_WRONG_CMD = 3'd2;
    localparam logic [2:0] STATUS_ERROR_BIT = 3'd3;
    localparam logic [2:0] STATUS_BAD_SUM   = 3'd4;
    localparam logic [2:0] STATUS_TRUNCATED = 3'd5;
    localparam logic [2:0] STATUS_NONE      = 3'd6;

    localparam logic [0:0] CFG_HAND_ID = 1'd0;
    localparam logic [0:0] CFG_COMMAND = 1'd1;

    localparam logic [7:0] HDR_FIRST = 8'h55;
    localparam logic [7:0] HDR_SECOND = 8'hAA;
    localparam logic [7:0] CMD_MASK = 8'h7F;
    localparam logic [7:0] CMD_ERR_BIT = 8'h80;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       buffer_end;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  command_code;
        logic [7:0]  payload_length;
        logic [63:0] payload_head;
        logic        end_of_search;
    } result_t;

    // up to two results from one byte; v1 only ever set together with v0
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t w0;
        result_t w1;
    } push_t;

endpackage

`default_nettype wire

/* rtl/rff_parser.sv */
`default_nettype none

module rff_parser #(
    parameter int HEAD_BYTES = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    output logic               item_stall,
    input  wire rff_pkg::item_t item,
    input  wire logic          cfg_we,
    input  wire logic [0:0]    cfg_index,
    input  wire logic [7:0]    cfg_data,
    input  wire logic          room,
    output rff_pkg::push_t     push
);
    import rff_pkg::*;

    localparam logic [2:0] PH_HUNT1   = 3'd0;
    localparam logic [2:0] PH_HUNT2   = 3'd1;
    localparam logic [2:0] PH_MASTER  = 3'd2;
    localparam logic [2:0] PH_ID      = 3'd3;
    localparam logic [2:0] PH_CMD     = 3'd4;
    localparam logic [2:0] PH_LEN     = 3'd5;
    localparam logic [2:0] PH_PAYLOAD = 3'd6;
    localparam logic [2:0] PH_CHECK   = 3'd7;

    logic        item_valid_reg;
    item_t       item_reg;
    logic        proceed;

    logic [7:0]  hand_id_reg;
    logic [6:0]  command_reg;

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  offset_reg, offset_next;
    logic [7:0]  id_reg, id_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  xor_reg, xor_next;
    logic [63:0] head_reg, head_next;
    logic        acc_reg, acc_next;

    logic [7:0]  b;
    logic [2:0]  chk_status;
    result_t     fin;
    push_t       res;

    assign proceed    = item_valid_reg && room;
    assign item_stall = item_valid_reg && !proceed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            item_reg       <= '0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                item_valid_reg <= 1'b1;
                item_reg       <= item;
            end
            else if (proceed)
            begin
                item_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hand_id_reg <= '0;
            command_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HAND_ID: hand_id_reg <= cfg_data;
                CFG_COMMAND: command_reg <= cfg_data[6:0];
                default:     hand_id_reg <= hand_id_reg;
            endcase
        end
    end

    always_comb
    begin
        b           = item_reg.rx_byte;
        phase_next  = phase_reg;
        offset_next = offset_reg;
        id_next     = id_reg;
        cmd_next    = cmd_reg;
        len_next    = len_reg;
        xor_next    = xor_reg;
        head_next   = head_reg;
        acc_next    = acc_reg;
        chk_status  = STATUS_ACCEPTED;
        res         = '0;
        fin         = '0;

        if (!acc_reg)
        begin
            case (phase_reg)
                PH_HUNT1:
                begin
                    if (b == HDR_FIRST)
                        phase_next = PH_HUNT2;
                end
                PH_HUNT2:
                begin
                    if (b == HDR_SECOND)
                    begin
                        phase_next  = PH_MASTER;
                        offset_next = '0;
                        id_next     = '0;
                        cmd_next    = '0;
                        len_next    = '0;
                        xor_next    = '0;
                        head_next   = '0;
                    end
                    else if (b != HDR_FIRST)
                    begin
                        phase_next = PH_HUNT1;
                    end
                end
                PH_MASTER:
                begin
                    xor_next   = b;
                    phase_next = PH_ID;
                end
                PH_ID:
                begin
                    id_next    = b;
                    xor_next   = xor_reg ^ b;
                    phase_next = PH_CMD;
                end
                PH_CMD:
                begin
                    cmd_next   = b;
                    xor_next   = xor_reg ^ b;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    len_next    = b;
                    xor_next    = xor_reg ^ b;
                    offset_next = '0;
                    phase_next  = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        if (i < HEAD_BYTES && offset_reg == 8'(i))
                            head_next[8*i +: 8] = head_reg[8*i +: 8] | b;
                    end
                    xor_next    = xor_reg ^ b;
                    offset_next = offset_reg + 8'd1;
                    if (offset_next == len_reg)
                        phase_next = PH_CHECK;
                end
                PH_CHECK:
                begin
                    // priority: id, command, error bit, checksum
                    if (id_reg != hand_id_reg)
                        chk_status = STATUS_WRONG_ID;
                    else if ((cmd_reg & CMD_MASK) != {1'b0, command_reg})
                        chk_status = STATUS_WRONG_CMD;
                    else if ((cmd_reg & CMD_ERR_BIT) != 8'd0)
                        chk_status = STATUS_ERROR_BIT;
                    else if (xor_reg != b)
                        chk_status = STATUS_BAD_SUM;
                    else
                        chk_status = STATUS_ACCEPTED;
                    res.v0                 = 1'b1;
                    res.w0.status          = chk_status;
                    res.w0.command_code    = cmd_reg;
                    res.w0.payload_length  = len_reg;
                    res.w0.payload_head    = head_reg;
                    res.w0.end_of_search   = (chk_status == STATUS_ACCEPTED);
                    acc_next   = (chk_status == STATUS_ACCEPTED);
                    phase_next = PH_HUNT1;
                end
                default:
                begin
                    phase_next = PH_HUNT1;
                end
            endcase
        end

        if (item_reg.buffer_end)
        begin
            if (!acc_next)
            begin
                fin.end_of_search = 1'b1;
                if (phase_next == PH_HUNT1 || phase_next == PH_HUNT2)
                begin
                    fin.status = STATUS_NONE;
                end
                else
                begin
                    fin.status         = STATUS_TRUNCATED;
                    fin.command_code   = cmd_next;
                    fin.payload_length = len_next;
                    fin.payload_head   = head_next;
                end
                if (res.v0)
                begin
                    res.v1 = 1'b1;
                    res.w1 = fin;
                end
                else
                begin
                    res.v0 = 1'b1;
                    res.w0 = fin;
                end
            end
            phase_next  = PH_HUNT1;
            offset_next = '0;
            id_next     = '0;
            cmd_next    = '0;
            len_next    = '0;
            xor_next    = '0;
            head_next   = '0;
            acc_next    = 1'b0;
        end

        push    = res;
        push.v0 = res.v0 && proceed;
        push.v1 = res.v1 && proceed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT1;
            offset_reg <= '0;
            id_reg     <= '0;
            cmd_reg    <= '0;
            len_reg    <= '0;
            xor_reg    <= '0;
            head_reg   <= '0;
            acc_reg    <= 1'b0;
        end
        else if (proceed)
        begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            id_reg     <= id_next;
            cmd_reg    <= cmd_next;
            len_reg    <= len_next;
            xor_reg    <= xor_next;
            head_reg   <= head_next;
            acc_reg    <= acc_next;
        end
    end

    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        push.v1 |-> push.v0)
        else $error("second result pushed without first");

    a_accept_parks_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        acc_reg |-> phase_reg == PH_HUNT1)
        else $error("accepted flag set outside hunt phase");

    a_held_word_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && !room) |=> (item_valid_reg && $stable(item_reg)))
        else $error("held word lost while result queue full");

    a_push_only_on_step: assert property (@(posedge clk) disable iff (!rst_n)
        push.v0 |-> proceed)
        else $error("result pushed without a processed word");

endmodule

`default_nettype wire

/* rtl/rff_out_fifo.sv */
`default_nettype none

module rff_out_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire rff_pkg::push_t   push,
    output logic                  room,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output rff_pkg::result_t      result
);
    import rff_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    result_t         mem [FIFO_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            pop;
    logic [CW-1:0]   n_push;
    logic [CW-1:0]   after_pop;

    assign result_valid = (count_reg != '0);
    assign result       = mem[rd_ptr_reg];
    assign pop          = result_valid && !result_stall;
    assign after_pop    = count_reg - CW'(pop);
    // room for two results after this cycle's pop
    assign room         = after_pop <= CW'(FIFO_DEPTH - 2);
    assign n_push       = CW'(push.v0) + CW'(push.v1);
    assign count_next   = after_pop + n_push;

    always_ff @(posedge clk)
    begin
        if (push.v0)
            mem[wr_ptr_reg] <= push.w0;
        if (push.v1)
            mem[wr_ptr_reg + PW'(1)] <= push.w1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PW'(n_push);
            rd_ptr_reg <= rd_ptr_reg + PW'(pop);
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.v0 |-> room)
        else $error("result pushed without room");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> count_reg == $past(count_next))
        else $error("queue count mismatch");

endmodule

`default_nettype wire

/* rtl/response_frame_finder_top.sv */
// channel  | valid        | stall        | word
// ---------+--------------+--------------+------------------------------
// item     | item_valid   | item_stall   | item   (rx_byte, buffer_end)
// result   | result_valid | result_stall | result (status .. end_of_search)
// config   | cfg_we       | -            | cfg_index, cfg_data
//
// One byte per cycle unless stalled: a byte sits in the input register while
// the frame parser updates its state and pushes zero, one or two results.
// Results leave through a 4-entry queue; the input stalls only when that
// queue could not take two more results after this cycle's pop.
// Reset clears the search state, the queue and both registers to zero.
`default_nettype none

module response_frame_finder_top #(
    parameter int HEAD_BYTES = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire rff_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output rff_pkg::result_t      result,
    input  wire logic             cfg_we,
    input  wire logic [0:0]       cfg_index,
    input  wire logic [7:0]       cfg_data
);
    import rff_pkg::*;

    push_t push;
    logic  room;

    rff_parser #(
        .HEAD_BYTES (HEAD_BYTES)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .room       (room),
        .push       (push)
    );

    rff_out_fifo u_out_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room         (room),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire
